// File: design/fci_pkg.sv
// Shared types and constants for the flash command interface.
`timescale 1ns / 1ps

package fci_pkg;

  // Stream payload layout
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int ADDR_FIELD_W = 20;
  localparam int MODE_LSB = 0;
  localparam int ADDR_LSB = 2;
  localparam int DATA_LSB = 22;
  localparam int VPP_BIT  = 30;
  localparam int BUSY_BIT = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERASE_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROG_TICKS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_FIRST    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_SECOND   = 2'd3;

  localparam logic [15:0] ERASE_TICKS_RST = 16'd100;
  localparam logic [15:0] PROG_TICKS_RST  = 16'd1;
  localparam logic [7:0]  ID_FIRST_RST    = 8'h00;
  localparam logic [7:0]  ID_SECOND_RST   = 8'h89;

  // Bus cycle kinds
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Command bytes
  localparam logic [7:0] CMD_READ_ARRAY  = 8'hFF;
  localparam logic [7:0] CMD_READ_ID     = 8'h90;
  localparam logic [7:0] CMD_READ_STATUS = 8'h70;
  localparam logic [7:0] CMD_CLEAR_ERR   = 8'h50;
  localparam logic [7:0] CMD_PROGRAM     = 8'h40;
  localparam logic [7:0] CMD_PROGRAM_ALT = 8'h10;
  localparam logic [7:0] CMD_ERASE       = 8'h20;
  localparam logic [7:0] CMD_CONFIRM     = 8'hD0;
  localparam logic [7:0] ERASED_BYTE     = 8'hFF;

  // Read modes
  localparam logic [1:0] RM_ARRAY  = 2'd0;
  localparam logic [1:0] RM_ID     = 2'd1;
  localparam logic [1:0] RM_STATUS = 2'd2;

  // Pending setup
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PROG  = 2'd1;
  localparam logic [1:0] PEND_ERASE = 2'd2;

  // Error bits (status bits 3, 4, 5)
  localparam logic [2:0] ERR_VPP   = 3'b001;
  localparam logic [2:0] ERR_PROG  = 3'b010;
  localparam logic [2:0] ERR_ERASE = 3'b100;

  typedef struct packed {
    logic capture;  // register the accepted item and start the array read
    logic commit;   // apply the item and load the result register
    logic sweep;    // write the erased byte at the sweep address
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;    // result register can take a new result
    logic erase_go;    // the item in hand is a confirmed erase
    logic sweep_last;  // sweep address is the last of its range
  } dp_status_t;

endpackage

// File: design/fci_ctrl.sv
// Controller state machine for the flash command interface.
`timescale 1ns / 1ps

module fci_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  fci_pkg::dp_status_t status,
  output fci_pkg::ctrl_cmd_t  cmd
);
  import fci_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_ERASE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    s_tready    = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = status.erase_go ? ST_ERASE : ST_IDLE;
        end
      end
      ST_ERASE: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.capture, cmd.commit, cmd.sweep}) <= 1)
    else $error("controller issued more than one datapath command");

  a_erase_follows_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status.erase_go) |=> state == ST_ERASE)
    else $error("confirmed erase did not start a block sweep");

  a_sweep_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ERASE && !status.sweep_last) |=> state == ST_ERASE)
    else $error("block sweep ended early");

endmodule

// File: design/fci_dp.sv
// Datapath of the flash command interface: array, command state, result register.
`timescale 1ns / 1ps

module fci_dp #(
  parameter int ADDRESS_BITS = 20,
  parameter int BLOCK_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fci_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fci_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_wr_en,
  input  logic [fci_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fci_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  fci_pkg::ctrl_cmd_t                  cmd,
  output fci_pkg::dp_status_t                 status
);
  import fci_pkg::*;

  localparam int AW     = ADDRESS_BITS;
  localparam int DEPTH  = 1 << ADDRESS_BITS;
  localparam int EFF_BB = (BLOCK_BITS < ADDRESS_BITS) ? BLOCK_BITS : ADDRESS_BITS;
  localparam logic [AW-1:0] BMASK = AW'((64'd1 << EFF_BB) - 64'd1);

  logic [7:0] mem [0:DEPTH-1];

  // Item in hand
  logic [1:0]    mode_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    data_q;
  logic          vpp_q;
  logic [7:0]    rdata;
  logic [AW-1:0] in_addr;

  // Device state
  logic [1:0]  read_mode, read_mode_next;
  logic [1:0]  pending, pending_next;
  logic [2:0]  err_bits, err_bits_next;
  logic [15:0] busy_count, busy_count_next;

  // Configuration
  logic [15:0] erase_ticks;
  logic [15:0] prog_ticks;
  logic [7:0]  id_first;
  logic [7:0]  id_second;

  // Sweep
  logic [AW-1:0] sweep_cnt;
  logic          sweep_full;
  logic [AW-1:0] sweep_addr;
  logic          sweep_last;

  logic          busy_nz;
  logic [7:0]    status_byte;
  logic [7:0]    rd;
  logic          prog_wr;
  logic          erase_go;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign in_addr = AW'(s_tdata[ADDR_LSB +: ADDR_FIELD_W]);

  assign sweep_addr = sweep_full ? sweep_cnt : ((addr_q & ~BMASK) | sweep_cnt);
  assign sweep_last = sweep_full ? (&sweep_cnt) : ((sweep_cnt & BMASK) == BMASK);

  assign busy_nz     = busy_count != 16'd0;
  assign status_byte = {~busy_nz, 1'b0, err_bits, 3'b000};

  always_comb begin
    rd              = 8'h00;
    read_mode_next  = read_mode;
    pending_next    = pending;
    err_bits_next   = err_bits;
    busy_count_next = busy_count;
    prog_wr         = 1'b0;
    erase_go        = 1'b0;
    case (mode_q)
      MODE_READ: begin
        case (read_mode)
          RM_STATUS: rd = status_byte;
          RM_ID:     rd = (addr_q == '0) ? id_first : id_second;
          default:   rd = rdata;
        endcase
      end
      MODE_WRITE: begin
        if (!busy_nz) begin
          if (pending == PEND_PROG) begin
            pending_next   = PEND_NONE;
            read_mode_next = RM_STATUS;
            if (!vpp_q) begin
              err_bits_next = err_bits | ERR_VPP | ERR_PROG;
            end else begin
              prog_wr         = 1'b1;
              busy_count_next = prog_ticks;
            end
          end else if (pending == PEND_ERASE) begin
            pending_next   = PEND_NONE;
            read_mode_next = RM_STATUS;
            if (data_q != CMD_CONFIRM) begin
              err_bits_next = err_bits | ERR_ERASE | ERR_PROG;
            end else if (!vpp_q) begin
              err_bits_next = err_bits | ERR_VPP | ERR_ERASE;
            end else begin
              erase_go        = 1'b1;
              busy_count_next = erase_ticks;
            end
          end else begin
            case (data_q)
              CMD_READ_ARRAY:  read_mode_next = RM_ARRAY;
              CMD_READ_ID:     read_mode_next = RM_ID;
              CMD_READ_STATUS: read_mode_next = RM_STATUS;
              CMD_CLEAR_ERR:   err_bits_next  = 3'b000;
              CMD_PROGRAM, CMD_PROGRAM_ALT: begin
                pending_next   = PEND_PROG;
                read_mode_next = RM_STATUS;
              end
              CMD_ERASE: begin
                pending_next   = PEND_ERASE;
                read_mode_next = RM_STATUS;
              end
              default: ;
            endcase
          end
        end
      end
      MODE_TICK: begin
        if (busy_nz) begin
          busy_count_next = busy_count - 16'd1;
        end
      end
      default: ;
    endcase
  end

  assign mem_we    = cmd.sweep || (cmd.commit && prog_wr);
  assign mem_waddr = cmd.sweep ? sweep_addr : addr_q;
  assign mem_wdata = cmd.sweep ? ERASED_BYTE : (rdata & data_q);

  // Array: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.capture) begin
      rdata <= mem[in_addr];
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= s_tdata[MODE_LSB +: 2];
      addr_q <= in_addr;
      data_q <= s_tdata[DATA_LSB +: 8];
      vpp_q  <= s_tdata[VPP_BIT];
    end
  end

  // Device state, sweep counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      read_mode  <= RM_ARRAY;
      pending    <= PEND_NONE;
      err_bits   <= 3'b000;
      busy_count <= 16'd0;
      sweep_cnt  <= '0;
      sweep_full <= 1'b1;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        read_mode  <= read_mode_next;
        pending    <= pending_next;
        err_bits   <= err_bits_next;
        busy_count <= busy_count_next;
        m_tvalid   <= 1'b1;
        if (erase_go) begin
          sweep_cnt  <= '0;
          sweep_full <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.sweep) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {7'd0, busy_count_next != 16'd0, rd};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      erase_ticks <= ERASE_TICKS_RST;
      prog_ticks  <= PROG_TICKS_RST;
      id_first    <= ID_FIRST_RST;
      id_second   <= ID_SECOND_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ERASE_TICKS: erase_ticks <= cfg_data;
        CFG_PROG_TICKS:  prog_ticks  <= cfg_data;
        CFG_ID_FIRST:    id_first    <= cfg_data[7:0];
        CFG_ID_SECOND:   id_second   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign status.out_free   = !m_tvalid || m_tready;
  assign status.erase_go   = erase_go;
  assign status.sweep_last = sweep_last;

  a_pending_not_busy: assert property (@(posedge clk) disable iff (rst)
    pending != PEND_NONE |-> busy_count == 16'd0)
    else $error("setup command pending while device busy");

  a_vpp_err_paired: assert property (@(posedge clk) disable iff (rst)
    err_bits[0] |-> (err_bits[1] || err_bits[2]))
    else $error("vpp error without program or erase error");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed item produced no result");

endmodule

// File: design/flash_command_interface.sv
// Top level of the flash command interface.
`timescale 1ns / 1ps

// Byte-wide flash device model with a command interface.
// Input stream (s_*): one transfer per bus cycle: a read, a write (command or
// program data) or a time tick. Output stream (m_*): exactly one result per
// input transfer, carrying the read byte (array, ID or status; 0 for writes
// and ticks) and the busy flag after that cycle.
// Configuration port: cfg_wr_en/cfg_index/cfg_data write the erase and program
// busy tick counts and the two ID bytes; write only while the block is idle.
// Timing: an item is accepted, its array read is registered, and the result is
// loaded into the output register in the execute state once that register is
// free; the block accepts no new item before the last one has committed.
// A confirmed block erase is followed by a sweep of the array memory's single
// write port over the block (the whole array if the block is larger), during
// which s_tready stays low; its result is already out.
// Reset: control state returns to read-array mode, no pending setup, no errors,
// not busy; then the array is cleared to 0xFF one byte per cycle, with s_tready
// low. Configuration writes are taken throughout. When m_tready is low the
// result holds in the output register; the next item may still be accepted but
// waits to commit until it drains.
module flash_command_interface #(
  parameter int ADDRESS_BITS = 20,
  parameter int BLOCK_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [1:0] mode, [21:2] address, [29:22] data, [30] vpp_ok, [31] zero
  input  logic [fci_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] read_data, [8] busy_res, [15:9] zero
  output logic [fci_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_wr_en,
  input  logic [fci_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fci_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fci_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence capture, commit and sweep
  fci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the array, command state, configuration and result register
  fci_dp #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .BLOCK_BITS   (BLOCK_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
